/* rtl/core/sru_pkg.sv */
// sound region detector shared package
// word and configuration types, register map and reset values
// no dependencies
package sru_pkg;

    localparam int ENV_W    = 17;
    localparam int THR_W    = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [2:0] REG_START_THR = 3'd0;
    localparam logic [2:0] REG_END_THR   = 3'd1;
    localparam logic [2:0] REG_HOLD      = 3'd2;
    localparam logic [2:0] REG_MIN_LEN   = 3'd3;
    localparam logic [2:0] REG_CHANNELS  = 3'd4;

    localparam logic [THR_W-1:0] RST_START_THR = 16'd380;
    localparam logic [THR_W-1:0] RST_END_THR   = 16'd90;
    localparam logic [THR_W-1:0] RST_HOLD      = 16'd28;
    localparam logic [THR_W-1:0] RST_MIN_LEN   = 16'd20;
    localparam logic [1:0]       RST_CHANNELS  = 2'd1;

    typedef struct packed {
        logic [THR_W-1:0] start_thr;
        logic [THR_W-1:0] end_thr;
        logic [THR_W-1:0] hold;
        logic [THR_W-1:0] min_len;
        logic [1:0]       channels;
    } sru_cfg_t;

    typedef struct packed {
        logic             eos;
        logic [ENV_W-1:0] env;
    } sru_item_t;

endpackage

/* rtl/core/sru_front.sv */
// front end: forms the envelope of each input word, the larger channel magnitude when two channels are on
// depends on sru_pkg
module sru_front #(
    parameter int MAX_CHANNELS = 2
) (
    input  logic signed [15:0] sample_first,
    input  logic signed [15:0] sample_second,
    input  logic               end_of_stream,
    input  sru_pkg::sru_cfg_t  cfg,
    output sru_pkg::sru_item_t item
);
    import sru_pkg::*;

    logic [ENV_W-1:0] abs_first;
    logic [ENV_W-1:0] abs_second;
    logic             use_second;

    // magnitude, so the most negative sample gives 32768
    assign abs_first  = sample_first[15] ? ({1'b0, ~sample_first} + 17'd1)
                                         : {1'b0, sample_first};
    assign abs_second = sample_second[15] ? ({1'b0, ~sample_second} + 17'd1)
                                          : {1'b0, sample_second};

    // counts of two and three both mean two channels
    assign use_second = (MAX_CHANNELS >= 2) && cfg.channels[1];

    always_comb
    begin
        item.eos = end_of_stream;
        if (use_second && (abs_second > abs_first))
        begin
            item.env = abs_second;
        end
        else
        begin
            item.env = abs_first;
        end
    end

endmodule

/* rtl/core/sru_queue.sv */
// two-entry word queue between front and back
// depends on sru_pkg
module sru_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sru_pkg::sru_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output sru_pkg::sru_item_t head_item
);
    import sru_pkg::*;

    sru_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue push lost");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

/* rtl/core/sru_back.sv */
// back end: region tracking, hold and length checks, result register
// depends on sru_pkg
module sru_back #(
    parameter int FRAME_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sru_pkg::sru_cfg_t  cfg,
    input  logic               head_valid,
    input  sru_pkg::sru_item_t head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        region_start,
    output logic [31:0]        region_end,
    output logic               closed_by_stream_end
);
    import sru_pkg::*;

    localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

    logic                  open_reg;
    logic                  open_next;
    logic [FRAME_BITS-1:0] start_reg;
    logic [FRAME_BITS-1:0] start_next;
    logic [FRAME_BITS-1:0] end_reg;
    logic [FRAME_BITS-1:0] end_next;
    logic [15:0]           quiet_reg;
    logic [15:0]           quiet_next;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [FRAME_BITS-1:0] out_start_reg;
    logic [FRAME_BITS-1:0] out_start_next;
    logic [FRAME_BITS-1:0] out_end_reg;
    logic [FRAME_BITS-1:0] out_end_next;
    logic                  out_eos_reg;
    logic                  out_eos_next;

    logic [FRAME_BITS-1:0] frame_inc;
    logic [15:0]           quiet_inc;
    logic [FRAME_BITS-1:0] span;
    logic                  long_enough;
    logic                  loud_start;
    logic                  loud_end;
    logic                  emit;
    logic                  emit_eos;
    logic [FRAME_BITS+31:0] start_ext;
    logic [FRAME_BITS+31:0] end_ext;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    // saturating counters
    assign frame_inc = (frame_reg == FRAME_MAX) ? frame_reg : frame_reg + 1'b1;
    assign quiet_inc = (quiet_reg == 16'hFFFF) ? quiet_reg : quiet_reg + 16'd1;

    assign span        = end_reg - start_reg;
    assign long_enough = (end_reg > start_reg) && (span >= FRAME_BITS'(cfg.min_len));
    assign loud_start  = head_item.env >= {1'b0, cfg.start_thr};
    assign loud_end    = head_item.env >= {1'b0, cfg.end_thr};

    always_comb
    begin
        open_next  = open_reg;
        start_next = start_reg;
        end_next   = end_reg;
        quiet_next = quiet_reg;
        frame_next = frame_reg;
        emit       = 1'b0;
        emit_eos   = 1'b0;
        if (pop)
        begin
            if (head_item.eos)
            begin
                emit       = open_reg && long_enough;
                emit_eos   = 1'b1;
                open_next  = 1'b0;
                quiet_next = 16'd0;
                frame_next = '0;
            end
            else
            begin
                frame_next = frame_inc;
                if (!open_reg)
                begin
                    if (loud_start)
                    begin
                        open_next  = 1'b1;
                        start_next = frame_reg;
                        end_next   = frame_inc;
                        quiet_next = 16'd0;
                    end
                end
                else if (loud_end)
                begin
                    end_next   = frame_inc;
                    quiet_next = 16'd0;
                end
                else if (quiet_inc >= cfg.hold)
                begin
                    // hold reached, region closes
                    emit       = long_enough;
                    open_next  = 1'b0;
                    quiet_next = 16'd0;
                end
                else
                begin
                    quiet_next = quiet_inc;
                end
            end
        end
    end

    always_comb
    begin
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_eos_next   = out_eos_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_start_next = start_reg;
            out_end_next   = end_reg;
            out_eos_next   = emit_eos;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        end_reg       <= end_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_eos_reg   <= out_eos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            quiet_reg     <= 16'd0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            quiet_reg     <= quiet_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // low 32 bits of the frame indices
    assign start_ext            = {32'd0, out_start_reg};
    assign end_ext              = {32'd0, out_end_reg};
    assign out_valid            = out_valid_reg;
    assign region_start         = start_ext[31:0];
    assign region_end           = end_ext[31:0];
    assign closed_by_stream_end = out_eos_reg;

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (quiet_reg == 16'd0))
        else $error("quiet count left over from a closed region");

    a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_end_reg > out_start_reg))
        else $error("reported region is empty");

    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.eos) |=> (frame_reg == '0) && !open_reg)
        else $error("end of stream did not restart numbering");
`endif

endmodule

/* rtl/core/sound_region_detector_unit.sv */
// sound region detector top level: register file, front, queue and back
// path: an accepted word is registered in the queue before the back end updates its region state and result register
// throughput: one word per cycle while no result waits on out_ready; a waiting result stalls the queue and in_ready
// reset: registers return to their defaults, region closed, frame count zero
// depends on sru_pkg, sru_front, sru_queue, sru_back
module sound_region_detector_unit #(
    parameter int FRAME_BITS   = 32,
    parameter int MAX_CHANNELS = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sru_pkg::ADDR_W-1:0]  paddr,
    input  logic [sru_pkg::DATA_W-1:0]  pwdata,
    output logic [sru_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [15:0]          sample_first,
    input  logic signed [15:0]          sample_second,
    input  logic                        end_of_stream,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 region_start,
    output logic [31:0]                 region_end,
    output logic                        closed_by_stream_end
);
    import sru_pkg::*;

    sru_cfg_t   cfg_reg;
    sru_cfg_t   cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;
    sru_item_t  front_item;
    sru_item_t  head_item;
    logic       q_full;
    logic       head_valid;
    logic       pop;
    logic       push;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_START_THR: cfg_next.start_thr = pwdata[15:0];
                REG_END_THR:   cfg_next.end_thr   = pwdata[15:0];
                REG_HOLD:      cfg_next.hold      = pwdata[15:0];
                REG_MIN_LEN:   cfg_next.min_len   = pwdata[15:0];
                REG_CHANNELS:  cfg_next.channels  = pwdata[1:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_THR: prdata = {16'd0, cfg_reg.start_thr};
            REG_END_THR:   prdata = {16'd0, cfg_reg.end_thr};
            REG_HOLD:      prdata = {16'd0, cfg_reg.hold};
            REG_MIN_LEN:   prdata = {16'd0, cfg_reg.min_len};
            REG_CHANNELS:  prdata = {30'd0, cfg_reg.channels};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_thr <= RST_START_THR;
            cfg_reg.end_thr   <= RST_END_THR;
            cfg_reg.hold      <= RST_HOLD;
            cfg_reg.min_len   <= RST_MIN_LEN;
            cfg_reg.channels  <= RST_CHANNELS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    sru_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .sample_first  (sample_first),
        .sample_second (sample_second),
        .end_of_stream (end_of_stream),
        .cfg           (cfg_reg),
        .item          (front_item)
    );

    sru_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    sru_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_reg),
        .head_valid           (head_valid),
        .head_item            (head_item),
        .pop                  (pop),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .region_start         (region_start),
        .region_end           (region_end),
        .closed_by_stream_end (closed_by_stream_end)
    );

endmodule
